// ===== rtl/evs_pkg.sv =====
package evs_pkg;

  localparam int MAX_EDITS   = 3;
  localparam int BAND_LEN    = 2 * MAX_EDITS + 1;
  localparam int CAP         = MAX_EDITS + 1;
  localparam int CAP_W       = $clog2(CAP + 1);
  localparam int ENTRY_W     = (CAP_W < 3) ? 3 : CAP_W;
  localparam int OUT_ENTRY_W = 3;
  localparam int MATCH_W     = 7;
  localparam int VEC_W       = 21;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 24;
  localparam int MASK_W      = (BAND_LEN > MATCH_W) ? BAND_LEN : MATCH_W;
  localparam int PACK_RAW_W  = BAND_LEN * OUT_ENTRY_W;
  localparam int PACK_W      = (PACK_RAW_W > VEC_W) ? PACK_RAW_W : VEC_W;

  typedef logic [ENTRY_W-1:0] entry_t;

  typedef enum logic {
    KIND_RESTART = 1'b0,
    KIND_STEP    = 1'b1
  } kind_t;

  function automatic entry_t init_entry(input int idx);
    int offset;
    begin
      offset = (idx >= MAX_EDITS) ? idx - MAX_EDITS : MAX_EDITS - idx;
      return ENTRY_W'(offset);
    end
  endfunction

endpackage

// ===== rtl/edit_vector_step.sv =====
// A result passes two registers on its way out, the input register and then the result
// FIFO. Throughput: one item per cycle while the result FIFO is not full; the 7-entry
// min chain sits between the input register and the 2-entry result FIFO, which lets a
// new item in while a result waits; a full FIFO holds the item in the input register.
// Reset (rst_n low, synchronous): band returns to the initial vector |i - K|,
// input stage and result FIFO empty.
module edit_vector_step (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [evs_pkg::IN_DATA_W-1:0]    in_tdata,   // [6:0] match_bits, [7] zero
  input  logic                             in_tuser,   // [0] kind
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [evs_pkg::OUT_DATA_W-1:0]   out_tdata,  // [20:0] edit_vector, [23:21] zero
  output logic                             out_tuser   // [0] is_terminal
);

  logic                          in_valid_r;
  evs_pkg::kind_t                kind_r;
  logic [evs_pkg::MATCH_W-1:0]   match_r;
  evs_pkg::entry_t               band_r   [evs_pkg::BAND_LEN];
  evs_pkg::entry_t               band_nxt [evs_pkg::BAND_LEN];
  evs_pkg::entry_t               step_v   [evs_pkg::BAND_LEN];
  evs_pkg::entry_t               old_ext  [evs_pkg::BAND_LEN+1];
  evs_pkg::entry_t               new_ext  [evs_pkg::BAND_LEN+1];
  logic [evs_pkg::MASK_W-1:0]    mask_ext;
  logic [evs_pkg::PACK_W-1:0]    pack_w;
  logic [evs_pkg::VEC_W-1:0]     vec_nxt;
  logic                          term_nxt;
  logic                          band_term;

  logic [evs_pkg::VEC_W:0]       fifo_r [2];
  logic                          wr_ptr_r;
  logic                          rd_ptr_r;
  logic [1:0]                    count_r;
  logic                          push;
  logic                          pop;
  logic                          in_xfer;

  assign push      = in_valid_r && (count_r != 2'd2);
  assign pop       = out_tvalid && out_tready;
  assign in_tready = !in_valid_r || push;
  assign in_xfer   = in_tvalid && in_tready;

  // band update: entries from 0 upward, new left / old right / old self
  always_comb begin
    logic [evs_pkg::ENTRY_W-1:0] m;
    logic [evs_pkg::ENTRY_W:0]   sum;
    mask_ext = evs_pkg::MASK_W'(match_r);
    old_ext[evs_pkg::BAND_LEN] = evs_pkg::ENTRY_W'(evs_pkg::CAP);
    new_ext[0] = evs_pkg::ENTRY_W'(evs_pkg::CAP);
    for (int i = 0; i < evs_pkg::BAND_LEN; i++) begin
      old_ext[i] = band_r[i];
    end
    for (int i = 0; i < evs_pkg::BAND_LEN; i++) begin
      m = (new_ext[i] < old_ext[i+1]) ? new_ext[i] : old_ext[i+1];
      if (old_ext[i] < m) begin
        m = old_ext[i];
      end
      if (mask_ext[evs_pkg::BAND_LEN-1-i]) begin
        sum = {1'b0, old_ext[i]};
      end else begin
        sum = {1'b0, m} + 1'b1;
      end
      if (sum > (evs_pkg::ENTRY_W+1)'(evs_pkg::CAP)) begin
        sum = (evs_pkg::ENTRY_W+1)'(evs_pkg::CAP);
      end
      step_v[i]    = sum[evs_pkg::ENTRY_W-1:0];
      new_ext[i+1] = step_v[i];
    end
  end

  always_comb begin
    term_nxt = 1'b1;
    pack_w   = '0;
    for (int i = 0; i < evs_pkg::BAND_LEN; i++) begin
      case (kind_r)
        evs_pkg::KIND_RESTART: band_nxt[i] = evs_pkg::init_entry(i);
        evs_pkg::KIND_STEP:    band_nxt[i] = step_v[i];
        default:               band_nxt[i] = step_v[i];
      endcase
      if (band_nxt[i] != evs_pkg::ENTRY_W'(evs_pkg::CAP)) begin
        term_nxt = 1'b0;
      end
      pack_w[i*evs_pkg::OUT_ENTRY_W +: evs_pkg::OUT_ENTRY_W] =
        band_nxt[i][evs_pkg::OUT_ENTRY_W-1:0];
    end
    vec_nxt = pack_w[evs_pkg::VEC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r  <= evs_pkg::kind_t'(in_tuser);
      match_r <= in_tdata[evs_pkg::MATCH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < evs_pkg::BAND_LEN; i++) begin
        band_r[i] <= evs_pkg::init_entry(i);
      end
    end else if (push) begin
      for (int i = 0; i < evs_pkg::BAND_LEN; i++) begin
        band_r[i] <= band_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= {term_nxt, vec_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  assign out_tvalid = (count_r != 2'd0);
  assign out_tdata  = {{(evs_pkg::OUT_DATA_W-evs_pkg::VEC_W){1'b0}},
                       fifo_r[rd_ptr_r][evs_pkg::VEC_W-1:0]};
  assign out_tuser  = fifo_r[rd_ptr_r][evs_pkg::VEC_W];

  always_comb begin
    band_term = 1'b1;
    for (int i = 0; i < evs_pkg::BAND_LEN; i++) begin
      if (band_r[i] != evs_pkg::ENTRY_W'(evs_pkg::CAP)) begin
        band_term = 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result FIFO overflow");

  a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("FIFO pointers out of step with count");

  a_restart_load: assert property (@(posedge clk) disable iff (!rst_n)
    (push && kind_r == evs_pkg::KIND_RESTART) |=>
      (band_r[evs_pkg::MAX_EDITS] == '0 && !band_term))
    else $error("restart did not load initial band");

  a_terminal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (push && kind_r == evs_pkg::KIND_STEP && band_term) |=> band_term)
    else $error("terminal band left terminal state");

  a_push_flag: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (fifo_r[$past(wr_ptr_r)][evs_pkg::VEC_W] == band_term))
    else $error("terminal flag disagrees with stored band");

endmodule

// ===== verif/edit_vector_step_tb.sv =====
module edit_vector_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [evs_pkg::VEC_W-1:0] vec;
    logic                      term;
  } band_out_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [evs_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                           in_tuser   = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [evs_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tuser;

  evs_pkg::entry_t band [evs_pkg::BAND_LEN];
  band_out_t       expected_vectors [$];
  int              errors     = 0;
  int              cycles     = 0;
  int              hold_left  = 0;
  int              ready_mode = 0;
  int              gap_mode   = 0;
  int              ready_ctr  = 0;

  edit_vector_step u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_vectors.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // band distance from the diagonal: |i - K|
  function automatic void load_start_band();
    for (int i = 0; i < evs_pkg::BAND_LEN; i++) begin
      band[i] = evs_pkg::entry_t'((i >= evs_pkg::MAX_EDITS) ? i - evs_pkg::MAX_EDITS
                                                           : evs_pkg::MAX_EDITS - i);
    end
  endfunction

  function automatic band_out_t step_band(evs_pkg::kind_t kind,
                                          logic [evs_pkg::MATCH_W-1:0] mask);
    evs_pkg::entry_t next_band [evs_pkg::BAND_LEN];
    int              left;
    int              right;
    int              least;
    int              v;
    band_out_t       r;
    if (kind == evs_pkg::KIND_RESTART) begin
      load_start_band();
    end else begin
      for (int i = 0; i < evs_pkg::BAND_LEN; i++) begin
        left  = (i > 0) ? int'(next_band[i-1]) : evs_pkg::CAP;
        right = (i < evs_pkg::BAND_LEN - 1) ? int'(band[i+1]) : evs_pkg::CAP;
        if (mask[evs_pkg::BAND_LEN-1-i]) begin
          v = int'(band[i]);
        end else begin
          least = (left < right) ? left : right;
          if (int'(band[i]) < least) least = int'(band[i]);
          v = least + 1;
        end
        if (v > evs_pkg::CAP) v = evs_pkg::CAP;
        next_band[i] = evs_pkg::entry_t'(v);
      end
      band = next_band;
    end
    r.vec  = '0;
    r.term = 1'b1;
    for (int i = 0; i < evs_pkg::BAND_LEN; i++) begin
      r.vec[i*evs_pkg::OUT_ENTRY_W +: evs_pkg::OUT_ENTRY_W] =
        band[i][evs_pkg::OUT_ENTRY_W-1:0];
      if (int'(band[i]) != evs_pkg::CAP) r.term = 1'b0;
    end
    return r;
  endfunction

  // mostly sparse masks, as a text character hits few band positions
  function automatic logic [evs_pkg::MATCH_W-1:0] random_mask();
    logic [evs_pkg::MATCH_W-1:0] m;
    case ($urandom_range(0, 4))
      0: m = evs_pkg::MATCH_W'($urandom);
      1: m = evs_pkg::MATCH_W'(1) << $urandom_range(0, evs_pkg::MATCH_W - 1);
      2: m = (evs_pkg::MATCH_W'(1) << $urandom_range(0, evs_pkg::MATCH_W - 1)) |
             (evs_pkg::MATCH_W'(1) << $urandom_range(0, evs_pkg::MATCH_W - 1));
      3: m = '0;
      default: m = evs_pkg::MATCH_W'(1) << $urandom_range(2, 4);
    endcase
    return m;
  endfunction

  always @(negedge clk) begin
    ready_ctr++;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (ready_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= (ready_ctr % 7) < 4;
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    band_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_vectors.size() == 0) begin
        $display("%0t: unexpected result edit_vector %h is_terminal %b",
                 $time, out_tdata[evs_pkg::VEC_W-1:0], out_tuser);
        errors++;
      end else begin
        want = expected_vectors.pop_front();
        if (out_tdata[evs_pkg::VEC_W-1:0] !== want.vec) begin
          $display("%0t: edit_vector expected %h got %h",
                   $time, want.vec, out_tdata[evs_pkg::VEC_W-1:0]);
          errors++;
        end
        if (out_tuser !== want.term) begin
          $display("%0t: is_terminal expected %b got %b", $time, want.term, out_tuser);
          errors++;
        end
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(evs_pkg::kind_t kind, logic [evs_pkg::MATCH_W-1:0] mask);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= evs_pkg::IN_DATA_W'(mask);
    do @(posedge clk); while (!in_tready);
    expected_vectors.insert(expected_vectors.size(), step_band(kind, mask));
    @(negedge clk);
  endtask

  task automatic pause_sender(int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (expected_vectors.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic test_reset_state();
    send_item(evs_pkg::KIND_STEP, 7'h7f);
    send_item(evs_pkg::KIND_STEP, 7'h00);
    send_item(evs_pkg::KIND_RESTART, 7'h7f);
  endtask

  // all-miss steps saturate the band; terminal must then hold for any mask
  task automatic test_run_to_terminal();
    send_item(evs_pkg::KIND_RESTART, 7'h00);
    repeat (5) send_item(evs_pkg::KIND_STEP, 7'h00);
    send_item(evs_pkg::KIND_STEP, 7'h7f);
    send_item(evs_pkg::KIND_STEP, 7'h55);
    send_item(evs_pkg::KIND_STEP, 7'h2a);
    send_item(evs_pkg::KIND_RESTART, 7'h00);
    send_item(evs_pkg::KIND_STEP, 7'h7f);
  endtask

  task automatic test_one_hot();
    for (int b = 0; b < evs_pkg::MATCH_W; b++) begin
      send_item(evs_pkg::KIND_STEP, evs_pkg::MATCH_W'(1) << b);
    end
    send_item(evs_pkg::KIND_RESTART, 7'h08);
  endtask

  task automatic test_backpressure();
    wait_results();
    ready_mode = 0;
    hold_left  = 80;
    for (int i = 0; i < 40; i++) begin
      send_item(($urandom_range(0, 9) == 0) ? evs_pkg::KIND_RESTART : evs_pkg::KIND_STEP,
                random_mask());
    end
    wait_results();
  endtask

  task automatic run_random(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int j = 0; j < burst && sent < count; j++) begin
        send_item(($urandom_range(0, 11) == 0) ? evs_pkg::KIND_RESTART : evs_pkg::KIND_STEP,
                  random_mask());
        sent++;
      end
      if (gap_mode != 0) pause_sender($urandom_range(0, 6));
    end
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 4; phase++) begin
      ready_mode = phase;
      gap_mode   = phase % 2;
      send_item(evs_pkg::KIND_RESTART, random_mask());
      run_random(260);
    end
    gap_mode = 1;
    run_random(60);
  endtask

  initial begin
    load_start_band();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_state();
    test_run_to_terminal();
    test_one_hot();
    test_backpressure();
    test_random();
    wait_results();
    if (errors == 0 && expected_vectors.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/evs_pkg.sv
rtl/edit_vector_step.sv
verif/edit_vector_step_tb.sv
